// File: rtl/tlbpt_pkg.sv
// Shared widths, limits and default sizes for the page translation block.
package tlbpt_pkg;

	localparam int ADDR_W = 20;
	localparam int CNT_W = 32;
	localparam int FAULT_W = 11;
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	localparam int DEF_TLB_ENTRIES = 16;
	localparam int DEF_PAGE_COUNT = 1024;
	localparam int DEF_OFFSET_WIDTH = 10;
	localparam int DEF_PAGE_W = $clog2(DEF_PAGE_COUNT);

endpackage

// File: rtl/tlbpt_cell.sv
// One TLB entry: holds a page/frame pair, matches the query, shifts toward older slots.
module tlbpt_cell #(
	parameter int TAG_W = tlbpt_pkg::DEF_PAGE_W,
	parameter int FRAME_W = tlbpt_pkg::DEF_PAGE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  logic               prev_valid,
	input  logic [TAG_W-1:0]   prev_page,
	input  logic [FRAME_W-1:0] prev_frame,
	input  logic [TAG_W-1:0]   query_page,
	output logic               valid,
	output logic [TAG_W-1:0]   page,
	output logic [FRAME_W-1:0] frame,
	output logic               match,
	output logic [FRAME_W-1:0] match_frame
);

	logic               valid_q;
	logic [TAG_W-1:0]   page_q;
	logic [FRAME_W-1:0] frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			page_q <= prev_page;
			frame_q <= prev_frame;
		end
	end

	assign valid = valid_q;
	assign page = page_q;
	assign frame = frame_q;
	assign match = valid_q && (page_q == query_page);
	// zero when not matching so the row can be OR-reduced
	assign match_frame = match ? frame_q : '0;

endmodule

// File: rtl/tlbpt_page_table.sv
// Page table memory: present bit and frame per page, swept clear after reset.
module tlbpt_page_table #(
	parameter int DEPTH = tlbpt_pkg::DEF_PAGE_COUNT,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = ADDR_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic              ready
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clearing_q) begin
			if (clr_idx_q == ADDR_W'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign ready = !clearing_q;

endmodule

// File: rtl/tlb_page_translation.sv
// Top level: virtual to physical translation through a shifting TLB and a demand-paged table.
//
//  channel | direction | handshake            | fields
//  --------+-----------+----------------------+------------------------------------------------
//  in      | input     | in_valid / in_stall  | virt_address
//  out     | output    | out_valid / out_stall| mapped_address, tlb_hit, page_fault,
//          |           |                      | translated_count, hit_count, fault_count
//
// A word passes through a reduction state (only when PAGE_COUNT is not a power of two and is
// smaller than the page field's range, for the reciprocal reduction of the page number), a
// TLB/page-table lookup state, registered by the table memory, then a resolve state with the
// table write-back. The next word is taken in the resolve state.
// After reset the page table is swept clear, with in_stall high until the sweep is done.
// A result held by out_stall holds the block in its resolve cycle.
module tlb_page_translation #(
	parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
	parameter int PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT,
	parameter int OFFSET_WIDTH = tlbpt_pkg::DEF_OFFSET_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tlbpt_pkg::ADDR_W-1:0]     virt_address,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tlbpt_pkg::ADDR_W-1:0]     mapped_address,
	output logic                             tlb_hit,
	output logic                             page_fault,
	output logic [tlbpt_pkg::CNT_W-1:0]      translated_count,
	output logic [tlbpt_pkg::CNT_W-1:0]      hit_count,
	output logic [tlbpt_pkg::FAULT_W-1:0]    fault_count
);

	localparam int AW = tlbpt_pkg::ADDR_W;
	localparam int PW = AW - OFFSET_WIDTH;
	localparam int PGW = $clog2(PAGE_COUNT);
	localparam int NFW = $clog2(PAGE_COUNT + 1);
	localparam int PHW = PGW + OFFSET_WIDTH;
	localparam bit PAGE_POW2 = (PAGE_COUNT == (1 << PGW));
	localparam bit NEED_MOD = !PAGE_POW2 && (PAGE_COUNT < (1 << PW));

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RED = 2'd1;
	localparam logic [1:0] ST_LOOK = 2'd2;
	localparam logic [1:0] ST_RES = 2'd3;
	localparam logic [1:0] ST_FIRST = NEED_MOD ? ST_RED : ST_LOOK;

	logic [1:0]              state_q, state_d;
	logic                    pt_ready;
	logic                    out_free;
	logic                    commit;
	logic                    in_acc;
	logic [PW-1:0]           page_raw;
	logic [OFFSET_WIDTH-1:0] offset_q;
	logic                    page_ld;
	logic [PGW-1:0]          page_d, page_q;

	logic [TLB_ENTRIES-1:0]  c_valid, c_match;
	logic [PGW-1:0]          c_page [TLB_ENTRIES];
	logic [PGW-1:0]          c_frame [TLB_ENTRIES];
	logic [PGW-1:0]          c_mframe [TLB_ENTRIES];
	logic                    hit_any;
	logic [PGW-1:0]          hit_frame;
	logic                    hit_s2;
	logic [PGW-1:0]          hframe_s2;
	logic                    tlb_shift;

	logic [PGW:0]            pt_rdata;
	logic                    pt_present;
	logic                    pt_wr;
	logic [NFW-1:0]          next_free_q;
	logic [PGW-1:0]          free_frame;
	logic                    fault_now;
	logic [PGW-1:0]          frame_res;
	logic [PHW+AW-1:0]       phys_w;

	logic                    out_valid_q;
	logic [AW-1:0]           phys_q;
	logic                    hit_q;
	logic                    fault_q;
	logic [tlbpt_pkg::CNT_W-1:0]   translated_q;
	logic [tlbpt_pkg::CNT_W-1:0]   hits_q;
	logic [tlbpt_pkg::FAULT_W-1:0] faults_q;

	assign out_free = !out_valid_q || !out_stall;
	assign commit = (state_q == ST_RES) && out_free;
	assign in_stall = !(pt_ready && ((state_q == ST_IDLE) || commit));
	assign in_acc = in_valid && !in_stall;
	assign page_raw = virt_address[AW-1:OFFSET_WIDTH];

	// page number reduced modulo PAGE_COUNT
	if (NEED_MOD) begin : g_mod
		localparam int RSH = PW + PGW;
		localparam int MW = PW + 1;
		localparam int PRW = PW + MW;
		localparam int RECIP = ((1 << RSH) + PAGE_COUNT - 1) / PAGE_COUNT;

		logic [PW-1:0]      raw_q;
		logic [PRW-1:0]     prod_q;
		logic [PRW-1:0]     quo_w;
		logic [PW-1:0]      quo;
		logic [PW+PGW-1:0]  qd_w;
		logic [PW-1:0]      rem;

		always_ff @(posedge clk) begin
			if (in_acc) begin
				raw_q <= page_raw;
				prod_q <= PRW'(page_raw) * PRW'(RECIP);
			end
		end

		assign quo_w = prod_q >> RSH;
		assign quo = quo_w[PW-1:0];
		assign qd_w = (PW + PGW)'(quo) * (PW + PGW)'(PAGE_COUNT);
		assign rem = raw_q - qd_w[PW-1:0];
		assign page_ld = (state_q == ST_RED);
		assign page_d = rem[PGW-1:0];
	end else begin : g_direct
		logic [PW+PGW-1:0] page_ext;

		assign page_ext = (PW + PGW)'(page_raw);
		assign page_ld = in_acc;
		assign page_d = page_ext[PGW-1:0];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			offset_q <= virt_address[OFFSET_WIDTH-1:0];
		end
		if (page_ld) begin
			page_q <= page_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_FIRST;
			end
			ST_RED: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (commit) state_d = in_acc ? ST_FIRST : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// TLB row: newest entry enters cell 0, the oldest drops off the far end
	assign tlb_shift = commit && !hit_s2;

	for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
		logic           p_valid;
		logic [PGW-1:0] p_page;
		logic [PGW-1:0] p_frame;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_page = page_q;
			assign p_frame = frame_res;
		end else begin : g_link
			assign p_valid = c_valid[i-1];
			assign p_page = c_page[i-1];
			assign p_frame = c_frame[i-1];
		end

		tlbpt_cell #(
			.TAG_W(PGW),
			.FRAME_W(PGW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (tlb_shift),
			.prev_valid (p_valid),
			.prev_page  (p_page),
			.prev_frame (p_frame),
			.query_page (page_q),
			.valid      (c_valid[i]),
			.page       (c_page[i]),
			.frame      (c_frame[i]),
			.match      (c_match[i]),
			.match_frame(c_mframe[i])
		);
	end

	// pages in the row are unique, so at most one cell matches
	always_comb begin
		hit_any = 1'b0;
		hit_frame = '0;
		for (int k = 0; k < TLB_ENTRIES; k++) begin
			hit_any = hit_any | c_match[k];
			hit_frame = hit_frame | c_mframe[k];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			hit_s2 <= hit_any;
			hframe_s2 <= hit_frame;
		end
	end

	tlbpt_page_table #(
		.DEPTH (PAGE_COUNT),
		.ADDR_W(PGW),
		.DATA_W(PGW + 1)
	) u_page_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (state_q == ST_LOOK),
		.rd_addr(page_q),
		.rd_data(pt_rdata),
		.wr_en  (pt_wr),
		.wr_addr(page_q),
		.wr_data({1'b1, free_frame}),
		.ready  (pt_ready)
	);

	assign pt_present = pt_rdata[PGW];
	assign fault_now = !hit_s2 && !pt_present;
	assign pt_wr = commit && fault_now;
	assign free_frame = (next_free_q == NFW'(PAGE_COUNT)) ? '0 : next_free_q[PGW-1:0];
	assign frame_res = hit_s2 ? hframe_s2 : (pt_present ? pt_rdata[PGW-1:0] : free_frame);
	assign phys_w = (PHW + AW)'({frame_res, offset_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			next_free_q <= '0;
			translated_q <= '0;
			hits_q <= '0;
			faults_q <= '0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit) begin
				if (translated_q != '1) translated_q <= translated_q + 1'b1;
				if (hit_s2 && (hits_q != '1)) hits_q <= hits_q + 1'b1;
				if (fault_now && (faults_q != tlbpt_pkg::FAULT_MAX)) begin
					faults_q <= faults_q + 1'b1;
				end
				if (fault_now && (next_free_q != NFW'(PAGE_COUNT))) begin
					next_free_q <= next_free_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			phys_q <= phys_w[AW-1:0];
			hit_q <= hit_s2;
			fault_q <= fault_now;
		end
	end

	// totals only move on commit, which also loads a fresh word
	assign out_valid = out_valid_q;
	assign mapped_address = phys_q;
	assign tlb_hit = hit_q;
	assign page_fault = fault_q;
	assign translated_count = translated_q;
	assign hit_count = hits_q;
	assign fault_count = faults_q;

endmodule

// File: rtl/tlbpt_checker.sv
// Port-level checks for the page translation block, bound to its top level.
module tlbpt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [tlbpt_pkg::ADDR_W-1:0]  mapped_address,
	input logic                          tlb_hit,
	input logic                          page_fault,
	input logic [tlbpt_pkg::CNT_W-1:0]   translated_count,
	input logic [tlbpt_pkg::CNT_W-1:0]   hit_count,
	input logic [tlbpt_pkg::FAULT_W-1:0] fault_count
);

	a_hit_fault_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_fault))
		else $error("word flags both a TLB hit and a page fault");

	a_hits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_count <= translated_count))
		else $error("hit count exceeds translated count");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && page_fault) |-> (fault_count != '0))
		else $error("page fault word with zero fault count");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(mapped_address)
			&& $stable(translated_count)))
		else $error("stalled output word changed");

endmodule

bind tlb_page_translation tlbpt_checker u_tlbpt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.mapped_address  (mapped_address),
	.tlb_hit         (tlb_hit),
	.page_fault      (page_fault),
	.translated_count(translated_count),
	.hit_count       (hit_count),
	.fault_count     (fault_count)
);

// File: tb/sv/testbench.sv
// Self-checking bench for tlb_page_translation: predicts each translation and compares it.
module testbench;

	localparam int ADDR_W = tlbpt_pkg::ADDR_W;
	localparam int CNT_W = tlbpt_pkg::CNT_W;
	localparam int FAULT_W = tlbpt_pkg::FAULT_W;
	localparam logic [FAULT_W-1:0] FAULT_MAX = tlbpt_pkg::FAULT_MAX;
	localparam int DEF_TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES;
	localparam int DEF_PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT;
	localparam int OFF_W = tlbpt_pkg::DEF_OFFSET_WIDTH;
	localparam int PAGE_W = tlbpt_pkg::DEF_PAGE_W;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 150;
	localparam int BURST_ITEMS = 40;
	localparam int PHASE_ITEMS = 348;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [ADDR_W-1:0]  mapped_address;
		logic               tlb_hit;
		logic               page_fault;
		logic [CNT_W-1:0]   translated_count;
		logic [CNT_W-1:0]   hit_count;
		logic [FAULT_W-1:0] fault_count;
	} xlat_t;

	class xlat_checker;
		logic [PAGE_W-1:0]  tlb_page [DEF_TLB_ENTRIES];
		logic [PAGE_W-1:0]  tlb_frame [DEF_TLB_ENTRIES];
		bit                 tlb_valid [DEF_TLB_ENTRIES];
		int unsigned        victim;
		logic [PAGE_W-1:0]  page_frame [DEF_PAGE_COUNT];
		bit                 page_present [DEF_PAGE_COUNT];
		logic [FAULT_W-1:0] next_free;
		logic [CNT_W-1:0]   translated_total;
		logic [CNT_W-1:0]   hit_total;
		logic [FAULT_W-1:0] fault_total;
		xlat_t              expected_xlat [$];
		int                 errors;

		function new();
			foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
			foreach (page_present[i]) page_present[i] = 1'b0;
			victim = 0;
			next_free = '0;
			translated_total = '0;
			hit_total = '0;
			fault_total = '0;
			errors = 0;
		endfunction

		// Translate one accepted address and queue the result it must produce.
		function void note_address(logic [ADDR_W-1:0] va);
			int unsigned page;
			logic [PAGE_W-1:0] frame;
			logic [CNT_W-1:0] wide;
			xlat_t r;
			page = (va >> OFF_W) % DEF_PAGE_COUNT;
			frame = '0;
			r = '0;
			if (translated_total != '1) translated_total++;
			for (int i = 0; i < DEF_TLB_ENTRIES; i++) begin
				if (!r.tlb_hit && tlb_valid[i] && tlb_page[i] == page) begin
					frame = tlb_frame[i];
					r.tlb_hit = 1'b1;
				end
			end
			if (r.tlb_hit) begin
				if (hit_total != '1) hit_total++;
			end else begin
				if (page_present[page]) begin
					frame = page_frame[page];
				end else begin
					// demand paging: hand out the next free frame
					r.page_fault = 1'b1;
					if (fault_total != FAULT_MAX) fault_total++;
					frame = PAGE_W'(next_free % DEF_PAGE_COUNT);
					page_frame[page] = frame;
					page_present[page] = 1'b1;
					if (next_free < DEF_PAGE_COUNT) next_free++;
				end
				tlb_page[victim] = PAGE_W'(page);
				tlb_frame[victim] = frame;
				tlb_valid[victim] = 1'b1;
				victim = (victim + 1) % DEF_TLB_ENTRIES;
			end
			wide = (CNT_W'(frame) << OFF_W) | CNT_W'(va[OFF_W-1:0]);
			r.mapped_address = wide[ADDR_W-1:0];
			r.translated_count = translated_total;
			r.hit_count = hit_total;
			r.fault_count = fault_total;
			expected_xlat.push_back(r);
		endfunction

		function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_xlat(xlat_t got);
			xlat_t want;
			if (expected_xlat.size() == 0) begin
				$display("%0t: unexpected word, expected none actual phys %0h",
					$time, got.mapped_address);
				errors++;
				return;
			end
			want = expected_xlat.pop_front();
			compare_field("mapped_address", CNT_W'(want.mapped_address),
				CNT_W'(got.mapped_address));
			compare_field("tlb_hit", CNT_W'(want.tlb_hit), CNT_W'(got.tlb_hit));
			compare_field("page_fault", CNT_W'(want.page_fault), CNT_W'(got.page_fault));
			compare_field("translated_count", want.translated_count, got.translated_count);
			compare_field("hit_count", want.hit_count, got.hit_count);
			compare_field("fault_count", CNT_W'(want.fault_count), CNT_W'(got.fault_count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ADDR_W-1:0] virt_address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ADDR_W-1:0] mapped_address;
	logic tlb_hit;
	logic page_fault;
	logic [CNT_W-1:0] translated_count;
	logic [CNT_W-1:0] hit_count;
	logic [FAULT_W-1:0] fault_count;

	xlat_checker sb;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;
	int idle_cycles = 0;
	int fresh_pages [DEF_PAGE_COUNT];
	int fresh_next = 0;

	tlb_page_translation DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.virt_address(virt_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mapped_address(mapped_address),
		.tlb_hit(tlb_hit),
		.page_fault(page_fault),
		.translated_count(translated_count),
		.hit_count(hit_count),
		.fault_count(fault_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watch both channels, feed the checker, and bail out if traffic stops.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_address(virt_address);
		if (arst_n && out_valid && !out_stall)
			sb.check_xlat(xlat_t'{mapped_address, tlb_hit, page_fault,
				translated_count, hit_count, fault_count});
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tlb_page_translation: mismatch");
			$finish;
		end
	end

	// Receiver: random stall, or a long hold when asked.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	task automatic send_address(input logic [ADDR_W-1:0] va);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		virt_address <= va;
		do @(posedge clk); while (in_stall);
	endtask

	// Pause the sender until every translation has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_xlat.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly TLB hits and first touches of unmapped pages, with some random pages.
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned roll;
		int unsigned slot;
		logic [PAGE_W-1:0] page;
		roll = $urandom_range(99);
		page = PAGE_W'($urandom_range(DEF_PAGE_COUNT - 1));
		if (roll < 25) begin
			slot = $urandom_range(DEF_TLB_ENTRIES - 1);
			if (sb.tlb_valid[slot]) page = sb.tlb_page[slot];
		end else if (roll < 90 && fresh_next < DEF_PAGE_COUNT) begin
			page = PAGE_W'(fresh_pages[fresh_next]);
			fresh_next++;
		end
		return {page, OFF_W'($urandom())};
	endfunction

	initial begin
		int j;
		int t;
		sb = new();
		foreach (fresh_pages[i]) fresh_pages[i] = i;
		for (int i = DEF_PAGE_COUNT - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = fresh_pages[i];
			fresh_pages[i] = fresh_pages[j];
			fresh_pages[j] = t;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lowest and highest page and offset, each seen first as a fault, then as a hit
		send_address({PAGE_W'(0), OFF_W'(0)});
		send_address({PAGE_W'(0), {OFF_W{1'b1}}});
		send_address({{PAGE_W{1'b1}}, {OFF_W{1'b1}}});
		send_address({{PAGE_W{1'b1}}, OFF_W'(0)});
		// sixteen new pages wrap the victim pointer and evict both
		for (int k = 1; k <= DEF_TLB_ENTRIES; k++)
			send_address({PAGE_W'(k), (k % 2) ? OFF_W'('h2AA) : OFF_W'('h155)});
		// evicted but present: miss without a fault
		send_address({PAGE_W'(0), OFF_W'('h155)});
		send_address({{PAGE_W{1'b1}}, OFF_W'('h2AA)});
		drain_results();

		// hold the output so the block backs up into its input
		hold_req = 1'b1;
		repeat (BURST_ITEMS) send_address(pick_address());
		drain_results();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 52; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 52; end
				default: begin idle_pct = 32; stall_pct = 32; end
			endcase
			repeat (PHASE_ITEMS) send_address(pick_address());
			drain_results();
		end

		if (sb.errors == 0) begin
			$display("tlb_page_translation: match");
		end else begin
			$display("tlb_page_translation: mismatch");
		end
		$finish;
	end

endmodule
